// ===== rtl/ajb_pkg.sv =====
package ajb_pkg;

  localparam int CNT_W          = 18;
  localparam int DATA_W         = 8;
  localparam int FUNC_W         = 2;
  localparam int CFG_IDX_W      = 2;
  localparam int RING_DEPTH_DEF = 131072;

  localparam logic [CNT_W-1:0] PRIME_RST = CNT_W'(39321);

  // register indexes on the config port
  localparam logic [CFG_IDX_W-1:0] REG_CAPACITY = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_PRIME    = CFG_IDX_W'(1);

  typedef enum logic [FUNC_W-1:0] {
    FUNC_PUSH    = 2'd0,
    FUNC_POP     = 2'd1,
    FUNC_DISCARD = 2'd2
  } func_t;

  typedef struct packed {
    logic [CNT_W-1:0] rp;
    logic [CNT_W-1:0] fill;
    logic             primed;
  } ring_state_t;

  typedef struct packed {
    logic [DATA_W-1:0] data;
    logic              valid;
    logic              dropped;
    logic [CNT_W-1:0]  fill;
    logic              primed;
    logic              last;
  } result_t;

  typedef struct packed {
    logic              en;
    logic [CNT_W-1:0]  addr;
    logic [DATA_W-1:0] data;
  } mem_wr_t;

endpackage

// ===== rtl/ajb_step.sv =====
module ajb_step (
  input  logic [ajb_pkg::CNT_W-1:0]  cap,
  input  logic [ajb_pkg::CNT_W-1:0]  prime,
  input  ajb_pkg::ring_state_t       st,
  input  logic [ajb_pkg::FUNC_W-1:0] func,
  input  logic [ajb_pkg::DATA_W-1:0] data_in,
  input  logic                       last_in,
  input  logic [ajb_pkg::DATA_W-1:0] rdata,
  output ajb_pkg::ring_state_t       st_nxt,
  output ajb_pkg::result_t           res,
  output ajb_pkg::mem_wr_t           wr
);
  import ajb_pkg::*;

  logic [CNT_W:0]   rp_plus;
  logic [CNT_W-1:0] rp_wrap;
  logic             full;
  logic [CNT_W-1:0] rp_push;
  logic [CNT_W-1:0] fill_push;
  logic [CNT_W:0]   tail_sum;
  logic [CNT_W:0]   tail_red;
  logic [CNT_W-1:0] prime_eff;
  logic             cap_zero;
  logic             go;

  assign cap_zero  = (cap == '0);
  assign rp_plus   = {1'b0, st.rp} + (CNT_W+1)'(1);
  assign rp_wrap   = (rp_plus >= {1'b0, cap}) ? '0 : rp_plus[CNT_W-1:0];
  assign full      = (st.fill >= cap);
  assign rp_push   = full ? rp_wrap : st.rp;
  assign fill_push = full ? (cap - CNT_W'(1)) : st.fill;
  assign tail_sum  = {1'b0, rp_push} + {1'b0, fill_push};
  assign tail_red  = (tail_sum >= {1'b0, cap}) ? (tail_sum - {1'b0, cap}) : tail_sum;
  assign prime_eff = (prime > cap) ? cap : prime;
  assign go        = st.primed || (st.fill >= prime_eff);

  always_comb begin
    st_nxt      = st;
    res.data    = '0;
    res.valid   = 1'b0;
    res.dropped = 1'b0;
    wr.en       = 1'b0;
    wr.addr     = tail_red[CNT_W-1:0];
    wr.data     = data_in;
    case (func)
      FUNC_PUSH: begin
        if (!cap_zero) begin
          st_nxt.rp   = rp_push;
          st_nxt.fill = fill_push + CNT_W'(1);
          res.dropped = full;
          wr.en       = 1'b1;
        end
      end
      FUNC_POP: begin
        if (!cap_zero && go) begin
          if (st.fill == '0) begin
            st_nxt.primed = 1'b0;
          end else begin
            st_nxt.primed = 1'b1;
            st_nxt.rp     = rp_wrap;
            st_nxt.fill   = st.fill - CNT_W'(1);
            res.data      = rdata;
            res.valid     = 1'b1;
          end
        end
      end
      FUNC_DISCARD: begin
        st_nxt = '0;
      end
      default: begin
        st_nxt = st;
      end
    endcase
    res.fill   = st_nxt.fill;
    res.primed = st_nxt.primed;
    res.last   = last_in;
  end

endmodule

// ===== rtl/audio_jitter_buffer.sv =====
// Byte-wide audio jitter buffer over a ring held in one synchronous RAM.
// Input channel (in_*): one request per byte operation. tuser carries the
// operation (push, pop, discard), tdata the byte to push, tlast the burst
// marker, which comes back unchanged on the result.
// Result channel (out_*): exactly one result per request, in order. tdata
// holds the popped byte, the drop flag, the fill level and the primed
// state; tuser says whether the byte is real.
// Config channel (cfg_*): index 0 sets the ring capacity (above RING_DEPTH
// it saturates) and empties the ring; index 1 sets the prime level, taken
// as the capacity when it is larger. Writes are taken only between requests.
// Timing: a request is registered while the RAM reads the head byte; the
// update step then updates pointers, writes a pushed byte and loads the
// output register. A new request is taken only after the update step of
// the last one, set by the read-then-update of the RAM, whose read data
// is registered.
// A stalled receiver holds the block in its update step; no request is
// taken until the output register can take the result.
// Reset empties the ring, clears primed and restores the register defaults.
// The RAM is not cleared; only bytes written since are ever read.
module audio_jitter_buffer #(
  parameter int RING_DEPTH = ajb_pkg::RING_DEPTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  // request channel
  input  logic                          in_tvalid,
  output logic                          in_tready,
  input  logic [7:0]                    in_tdata,  // [7:0] data_in
  input  logic                          in_tlast,  // last_in_burst
  input  logic [ajb_pkg::FUNC_W-1:0]    in_tuser,  // [1:0] func
  // result channel
  output logic                          out_tvalid,
  input  logic                          out_tready,
  // [7:0] data_out, [8] dropped_oldest, [26:9] fill_level, [27] primed_now,
  // [31:28] zero
  output logic [31:0]                   out_tdata,
  output logic                          out_tlast, // last_out
  output logic [0:0]                    out_tuser, // [0] data_valid
  // config channel
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [ajb_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [ajb_pkg::CNT_W-1:0]     cfg_data
);
  import ajb_pkg::*;

  localparam int ADDR_W = $clog2(RING_DEPTH);
  localparam logic [31:0] DEPTH_V = 32'(RING_DEPTH);
  // reset capacity: depth cut to the register width
  localparam logic [CNT_W-1:0] CAP_RST = CNT_W'(RING_DEPTH);

  typedef enum logic {
    S_IDLE,
    S_EXEC
  } state_t;

  state_t            state_r;
  ring_state_t       ring_r;
  ring_state_t       ring_nxt;
  logic [CNT_W-1:0]  cap_r;
  logic [CNT_W-1:0]  prime_r;
  logic [CNT_W-1:0]  cap_sat;
  logic [FUNC_W-1:0] func_r;
  logic [DATA_W-1:0] data_r;
  logic              last_r;
  logic              out_valid_r;
  result_t           out_res_r;
  result_t           res;
  mem_wr_t           wr;
  logic [DATA_W-1:0] rdata_r;
  logic              in_acc;
  logic              cfg_acc;
  logic              done;

  logic [DATA_W-1:0] store_mem [RING_DEPTH];

  assign cfg_ready = (state_r == S_IDLE);
  assign in_tready = (state_r == S_IDLE) && !cfg_valid;
  assign in_acc    = in_tvalid && in_tready;
  assign cfg_acc   = cfg_valid && cfg_ready;
  assign done      = (state_r == S_EXEC) && (!out_valid_r || out_tready);
  assign cap_sat   = ({{(32-CNT_W){1'b0}}, cfg_data} > DEPTH_V) ? DEPTH_V[CNT_W-1:0]
                                                                 : cfg_data;

  // RAM: head byte read every cycle, pushed byte written on update
  always_ff @(posedge clk) begin
    if (done && wr.en) begin
      store_mem[ADDR_W'(wr.addr)] <= wr.data;
    end
    rdata_r <= store_mem[ADDR_W'(ring_r.rp)];
  end

  ajb_step u_step (
    .cap     (cap_r),
    .prime   (prime_r),
    .st      (ring_r),
    .func    (func_r),
    .data_in (data_r),
    .last_in (last_r),
    .rdata   (rdata_r),
    .st_nxt  (ring_nxt),
    .res     (res),
    .wr      (wr)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      ring_r      <= '0;
      cap_r       <= CAP_RST;
      prime_r     <= PRIME_RST;
      out_valid_r <= 1'b0;
    end else begin
      // a finished update refills the output register, else a taken result empties it
      if (done) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (cfg_acc) begin
            if (cfg_index == REG_CAPACITY) begin
              cap_r  <= cap_sat;
              ring_r <= '0;
            end else if (cfg_index == REG_PRIME) begin
              prime_r <= cfg_data;
            end
          end
          if (in_acc) begin
            state_r <= S_EXEC;
          end
        end
        S_EXEC: begin
          if (done) begin
            ring_r      <= ring_nxt;
            state_r     <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  // request and result payload
  always_ff @(posedge clk) begin
    if (in_acc) begin
      func_r <= in_tuser;
      data_r <= in_tdata;
      last_r <= in_tlast;
    end
    if (done) begin
      out_res_r <= res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {4'b0, out_res_r.primed, out_res_r.fill, out_res_r.dropped,
                       out_res_r.data};
  assign out_tlast  = out_res_r.last;
  assign out_tuser  = out_res_r.valid;

  a_fill_in_cap: assert property (@(posedge clk) disable iff (!rst_n)
    ring_r.fill <= cap_r)
    else $error("fill count above capacity");

  a_rp_in_ring: assert property (@(posedge clk) disable iff (!rst_n)
    (ring_r.rp < cap_r) || (ring_r.rp == '0))
    else $error("read pointer outside ring");

  a_no_data_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser[0] |-> (out_tdata[7:0] == '0))
    else $error("data without valid byte");

  a_exec_one: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_EXEC) && !out_valid_r |=> (state_r == S_IDLE) && out_valid_r)
    else $error("update step did not complete");

endmodule
